// ===== hdl/langevin_euler_window_step_unit_macros.svh =====
// assertion macros shared by the langevin euler window step unit modules
`ifndef LANGEVIN_EULER_WINDOW_STEP_UNIT_MACROS_SVH
`define LANGEVIN_EULER_WINDOW_STEP_UNIT_MACROS_SVH

// same-cycle implication, checked on every rising edge outside reset
`define LEWS_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on every rising edge outside reset
`define LEWS_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/lews_pkg.sv =====
// shared types and constants of the langevin euler window step unit
`default_nettype none

package lews_pkg;

  localparam int SUM_W  = 48;
  localparam int HALF_W = SUM_W / 2;
  localparam int Q_ONE  = 65536;

  // 0.1*sqrt(2) in q16.16, truncated
  localparam logic [13:0] NOISE_GAIN = 14'd9268;

  typedef enum logic [2:0] {
    CFG_STEP_SIZE      = 3'd0,
    CFG_STREAM_SPEED   = 3'd1,
    CFG_START_POSITION = 3'd2,
    CFG_START_VELOCITY = 3'd3,
    CFG_SHORT_LENGTH   = 3'd4,
    CFG_LONG_LENGTH    = 3'd5,
    CFG_SHORT_SCALE    = 3'd6,
    CFG_LONG_SCALE     = 3'd7
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_UPD,
    ST_MEAN,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic        [16:0] step_size;
    logic signed [31:0] stream_speed;
    logic signed [31:0] start_position;
    logic signed [31:0] start_velocity;
    logic        [12:0] short_window_length;
    logic        [14:0] long_window_length;
    logic        [16:0] short_window_scale;
    logic        [16:0] long_window_scale;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    step_size:           17'd328,
    stream_speed:        32'sd131072,
    start_position:      -32'sd249037,
    start_velocity:      -32'sd42992,
    short_window_length: 13'd4000,
    long_window_length:  15'd10000,
    short_window_scale:  17'd3277,
    long_window_scale:   17'd1311
  };

  typedef struct packed {
    logic signed [31:0] noise_sample;
    logic               restart;
  } in_t;

  typedef struct packed {
    logic signed [31:0] position;
    logic signed [31:0] velocity;
    logic signed [31:0] short_work_mean;
    logic signed [31:0] long_work_mean;
  } out_t;

  typedef struct packed {
    logic accept;
    logic mul;
    logic upd;
    logic mean;
    logic fin;
  } cmd_t;

endpackage

`default_nettype wire

// ===== hdl/lews_ctrl.sv =====
// step sequencer and output handshake for the langevin euler window step unit
`default_nettype none
`include "langevin_euler_window_step_unit_macros.svh"

module lews_ctrl (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output lews_pkg::cmd_t    cmd_o
);
  import lews_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_MUL;
      end
      ST_MUL:  state_d = ST_UPD;
      ST_UPD:  state_d = ST_MEAN;
      ST_MEAN: state_d = ST_FIN;
      ST_FIN: begin
        if (out_free) state_d = in_valid_i ? ST_MUL : ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_MUL:  cmd_o.mul  = 1'b1;
      ST_UPD:  cmd_o.upd  = 1'b1;
      ST_MEAN: cmd_o.mean = 1'b1;
      ST_FIN: begin
        in_ready_o = out_free;
        cmd_o.fin  = out_free;
      end
      default: in_ready_o = 1'b0;
    endcase
    cmd_o.accept = in_valid_i && in_ready_o;
    if (cmd_o.fin) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `LEWS_ASSERT_NXT(a_accept_starts_step, cmd_o.accept, state_q == ST_MUL,
    "accepted beat did not start the multiply step")
  `LEWS_ASSERT_IMP(a_result_from_fin, $rose(out_valid_q), $past(state_q) == ST_FIN,
    "result raised outside the final step")
  `LEWS_ASSERT_NXT(a_stall_holds_fin, state_q == ST_FIN && out_valid_q && !out_ready_i,
    state_q == ST_FIN && out_valid_q, "stalled result was dropped")

endmodule

`default_nettype wire

// ===== hdl/lews_window.sv =====
// sliding-window work sum over a ring memory with a fill count
`default_nettype none
`include "langevin_euler_window_step_unit_macros.svh"

module lews_window #(
  parameter int DEPTH = 4096,
  parameter int LEN_W = 13
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              clear_i,
  input  wire logic                              lookup_i,
  input  wire logic                              push_i,
  input  wire logic signed [31:0]                w_i,
  input  wire logic        [LEN_W-1:0]           len_i,
  output logic signed      [lews_pkg::SUM_W-1:0] sum_o
);
  import lews_pkg::*;

  localparam int AW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (LEN_W > CNT_W) ? LEN_W : CNT_W;

  logic signed [31:0]       mem [DEPTH];
  logic signed [31:0]       rd_q;
  logic        [AW-1:0]     ptr_q, ptr_d;
  logic        [AW-1:0]     p_q, p_cur;
  logic        [CNT_W-1:0]  fill_q, fill_d;
  logic        [CNT_W-1:0]  len_eff, p_inc;
  logic                     hit_q;
  logic signed [SUM_W-1:0]  sum_q, sum_d;
  logic signed [31:0]       old_w;

  // zero length acts as one, length beyond the ring is clamped
  always_comb begin
    if (len_i == '0) begin
      len_eff = CNT_W'(1);
    end else if (CMP_W'(len_i) > CMP_W'(DEPTH)) begin
      len_eff = CNT_W'(DEPTH);
    end else begin
      len_eff = CNT_W'(len_i);
    end
  end

  // pointer left past a shrunk window restarts at slot zero
  assign p_cur = (CNT_W'(ptr_q) >= len_eff) ? '0 : ptr_q;
  assign p_inc = CNT_W'(p_q) + CNT_W'(1);
  assign old_w = hit_q ? rd_q : '0;

  always_comb begin
    ptr_d  = ptr_q;
    fill_d = fill_q;
    sum_d  = sum_q;
    if (clear_i) begin
      ptr_d  = '0;
      fill_d = '0;
      sum_d  = '0;
    end else if (push_i) begin
      sum_d = sum_q + SUM_W'(w_i) - SUM_W'(old_w);
      ptr_d = (p_inc >= len_eff) ? '0 : p_inc[AW-1:0];
      if (CNT_W'(p_q) == fill_q) fill_d = fill_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q  <= '0;
      fill_q <= '0;
      sum_q  <= '0;
    end else begin
      ptr_q  <= ptr_d;
      fill_q <= fill_d;
      sum_q  <= sum_d;
    end
  end

  // slots at or above the fill count were not written since the last clear
  always_ff @(posedge clk_i) begin
    if (lookup_i) begin
      p_q   <= p_cur;
      hit_q <= CNT_W'(p_cur) < fill_q;
      rd_q  <= mem[p_cur];
    end
    if (push_i) mem[p_q] <= w_i;
  end

  assign sum_o = sum_q;

  `LEWS_ASSERT_IMP(a_fill_bound, 1'b1, fill_q <= CNT_W'(DEPTH),
    "fill count beyond ring depth")
  `LEWS_ASSERT_IMP(a_push_contiguous, push_i, CNT_W'(p_q) <= fill_q,
    "ring write leaves a gap above the fill count")
  `LEWS_ASSERT_NXT(a_clear_empties, clear_i, fill_q == '0 && ptr_q == '0 && sum_q == '0,
    "clear left window state behind")

endmodule

`default_nettype wire

// ===== hdl/lews_datapath.sv =====
// particle state, q16.16 products and result register of the step unit
`default_nettype none

module lews_datapath #(
  parameter int SHORT_DEPTH = 4096,
  parameter int LONG_DEPTH  = 16384
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire lews_pkg::cfg_t cfg_i,
  input  wire lews_pkg::cmd_t cmd_i,
  input  wire lews_pkg::in_t  in_data_i,
  output lews_pkg::out_t      out_data_o
);
  import lews_pkg::*;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v[63:31] == '0 || v[63:31] == '1) begin
      r = v[31:0];
    end else if (v[63]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7FFF_FFFF;
    end
    return r;
  endfunction

  logic signed [17:0] dt;
  logic signed [31:0] pos_q, vel_q, noise_q;
  logic signed [49:0] a_prod_q;
  logic signed [31:0] a_sat;
  logic signed [32:0] neg_a;
  logic signed [32:0] vs_sum;
  logic signed [33:0] s_neg, drift;
  logic signed [64:0] prod_w_d, prod_w_q;
  logic signed [49:0] prod_pv_d, prod_pv_q;
  logic signed [51:0] prod_vx_d, prod_vx_q;
  logic signed [46:0] prod_n_d, prod_n_q;
  logic signed [31:0] npos, nvel, w;
  logic               win_clear;
  logic signed [SUM_W-1:0] short_sum, long_sum;
  logic signed [HALF_W+17:0] s_hi_q, l_hi_q;
  logic signed [HALF_W+18:0] s_lo_q, l_lo_q;
  logic signed [HALF_W+26:0] s_mean, l_mean;
  out_t out_q;

  assign dt = $signed({1'b0, cfg_i.step_size});

  // stream speed times dt only follows the registers
  always_ff @(posedge clk_i) begin
    a_prod_q <= cfg_i.stream_speed * dt;
  end

  always_comb begin
    a_sat  = sat32(64'($signed(a_prod_q[49:16])));
    neg_a  = -33'(a_sat);
    vs_sum = 33'(vel_q) + 33'(cfg_i.stream_speed);
    if (vs_sum > 33'sd0) begin
      s_neg = -34'(Q_ONE);
    end else if (vs_sum < 33'sd0) begin
      s_neg = 34'(Q_ONE);
    end else begin
      s_neg = '0;
    end
    drift     = s_neg - 34'(pos_q);
    prod_w_d  = neg_a * pos_q;
    prod_pv_d = vel_q * dt;
    prod_vx_d = drift * dt;
    prod_n_d  = noise_q * $signed({1'b0, NOISE_GAIN});
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) noise_q <= in_data_i.noise_sample;
    if (cmd_i.mul) begin
      prod_w_q  <= prod_w_d;
      prod_pv_q <= prod_pv_d;
      prod_vx_q <= prod_vx_d;
      prod_n_q  <= prod_n_d;
    end
  end

  // floor shift is a drop of the low sixteen bits
  always_comb begin
    w    = sat32(64'($signed(prod_w_q[64:16])));
    npos = sat32(64'(35'(pos_q) + 35'($signed(prod_pv_q[49:16]))));
    nvel = sat32(64'(38'(vel_q) + 38'($signed(prod_vx_q[51:16]))
                     + 38'($signed(prod_n_q[46:16]))));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= CFG_RESET.start_position;
      vel_q <= CFG_RESET.start_velocity;
    end else if (cmd_i.accept && in_data_i.restart) begin
      pos_q <= cfg_i.start_position;
      vel_q <= cfg_i.start_velocity;
    end else if (cmd_i.upd) begin
      pos_q <= npos;
      vel_q <= nvel;
    end
  end

  assign win_clear = cmd_i.accept && in_data_i.restart;

  lews_window #(
    .DEPTH (SHORT_DEPTH),
    .LEN_W (13)
  ) u_short (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .clear_i  (win_clear),
    .lookup_i (cmd_i.mul),
    .push_i   (cmd_i.upd),
    .w_i      (w),
    .len_i    (cfg_i.short_window_length),
    .sum_o    (short_sum)
  );

  lews_window #(
    .DEPTH (LONG_DEPTH),
    .LEN_W (15)
  ) u_long (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .clear_i  (win_clear),
    .lookup_i (cmd_i.mul),
    .push_i   (cmd_i.upd),
    .w_i      (w),
    .len_i    (cfg_i.long_window_length),
    .sum_o    (long_sum)
  );

  // sum times scale in two half-width partial products
  always_ff @(posedge clk_i) begin
    if (cmd_i.mean) begin
      s_hi_q <= $signed(short_sum[SUM_W-1:HALF_W]) * $signed({1'b0, cfg_i.short_window_scale});
      s_lo_q <= $signed({1'b0, short_sum[HALF_W-1:0]})
                * $signed({1'b0, cfg_i.short_window_scale});
      l_hi_q <= $signed(long_sum[SUM_W-1:HALF_W]) * $signed({1'b0, cfg_i.long_window_scale});
      l_lo_q <= $signed({1'b0, long_sum[HALF_W-1:0]})
                * $signed({1'b0, cfg_i.long_window_scale});
    end
  end

  always_comb begin
    s_mean = ((HALF_W + 27)'(s_hi_q) <<< (HALF_W - 16))
             + (HALF_W + 27)'($signed({1'b0, s_lo_q[HALF_W+18:16]}));
    l_mean = ((HALF_W + 27)'(l_hi_q) <<< (HALF_W - 16))
             + (HALF_W + 27)'($signed({1'b0, l_lo_q[HALF_W+18:16]}));
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin) begin
      out_q.position        <= pos_q;
      out_q.velocity        <= vel_q;
      out_q.short_work_mean <= sat32(64'(s_mean));
      out_q.long_work_mean  <= sat32(64'(l_mean));
    end
  end

  assign out_data_o = out_q;

endmodule

`default_nettype wire

// ===== hdl/langevin_euler_window_step_unit.sv =====
// top level of the langevin euler window step unit
`default_nettype none

// One Euler-Maruyama step of a Langevin particle per input beat. The beat
// carries a Gaussian noise sample (q16.16, spread sqrt(dt)) and a restart
// flag; restart reloads the start position and velocity and empties both
// work windows before the step. Every beat yields exactly one result beat:
// new position, new velocity, and the short and long window work sums times
// their reciprocal window times, all signed q16.16, floored and saturated.
// From acceptance an item passes the multiply step with the ring read, the
// update with the ring write, the window scaling and the result load in that order, and
// a new item is taken in the cycle the previous result is loaded while the
// result side keeps up, so an item is taken only once the one before is
// through. This follows from the dependence of each step on the position and
// velocity left by the one before, through one product stage and one
// single-port access per ring memory. The rings hold SHORT_DEPTH and
// LONG_DEPTH words; a fill count marks which slots were written since the
// last reset or restart, so neither needs a clearing pass and the unit takes
// items right after reset. Configuration writes are taken every cycle and
// must only happen while no step is in flight.

module langevin_euler_window_step_unit #(
  parameter int SHORT_DEPTH = 4096,
  parameter int LONG_DEPTH  = 16384
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  // configuration write channel
  input  wire logic            cfg_valid_i,
  output logic                 cfg_ready_o,
  input  wire logic [2:0]      cfg_index_i,
  input  wire logic [31:0]     cfg_data_i,
  // noise beats in
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire lews_pkg::in_t   in_data_i,
  // result beats out
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output lews_pkg::out_t       out_data_o
);
  import lews_pkg::*;

  cfg_t cfg_q;
  cmd_t cmd;

  // register file, always ready, each write truncated to its field width
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_STEP_SIZE:      cfg_q.step_size           <= cfg_data_i[16:0];
        CFG_STREAM_SPEED:   cfg_q.stream_speed        <= $signed(cfg_data_i);
        CFG_START_POSITION: cfg_q.start_position      <= $signed(cfg_data_i);
        CFG_START_VELOCITY: cfg_q.start_velocity      <= $signed(cfg_data_i);
        CFG_SHORT_LENGTH:   cfg_q.short_window_length <= cfg_data_i[12:0];
        CFG_LONG_LENGTH:    cfg_q.long_window_length  <= cfg_data_i[14:0];
        CFG_SHORT_SCALE:    cfg_q.short_window_scale  <= cfg_data_i[16:0];
        CFG_LONG_SCALE:     cfg_q.long_window_scale   <= cfg_data_i[16:0];
        default:            cfg_q                     <= cfg_q;
      endcase
    end
  end

  // sequencer: owns both handshakes and steps the datapath
  lews_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // particle state, products, ring windows and the result register
  lews_datapath #(
    .SHORT_DEPTH (SHORT_DEPTH),
    .LONG_DEPTH  (LONG_DEPTH)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .cmd_i      (cmd),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// self-checking testbench for the langevin euler window step unit
`default_nettype none

module tb;
  import lews_pkg::*;

  localparam int SHORT_DEPTH = 4096;
  localparam int LONG_DEPTH  = 16384;
  // no new random phase starts once this many steps went in
  localparam int ITEM_TARGET = 1250;
  // the longest legal quiet stretch is well under this limit
  localparam int QUIET_LIMIT = 5000;
  localparam int SHOWN_MAX   = 10;

  logic  clk_i;
  logic  rst_ni;
  logic  cfg_valid_i;
  logic  cfg_ready_o;
  logic  [2:0] cfg_index_i;
  logic  [31:0] cfg_data_i;
  logic  in_valid_i;
  logic  in_ready_o;
  in_t   in_data_i;
  logic  out_valid_o;
  logic  out_ready_i;
  out_t  out_data_o;

  langevin_euler_window_step_unit #(
    .SHORT_DEPTH(SHORT_DEPTH),
    .LONG_DEPTH (LONG_DEPTH)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // ---------------------------------------------------------------------
  // particle and window model, updated at every accepted beat
  // ---------------------------------------------------------------------
  cfg_t   model_cfg;
  longint pos_q;
  longint vel_q;
  longint short_win [SHORT_DEPTH];
  longint long_win  [LONG_DEPTH];
  longint short_total;
  longint long_total;
  int     short_at;
  int     long_at;

  // predicted result beats, oldest first
  out_t   pending_results[$];

  // knobs for the random idling on both sides
  bit     in_gaps_on;
  bit     out_stalls_on;

  int     n_items;
  int     n_results;
  int     n_restarts;
  int     n_reg_writes;
  int     n_phases;
  int     n_errors;
  int     quiet_cycles;

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // length register to effective window: zero acts as one, clamp to depth
  function automatic int window_len(int raw, int depth);
    if (raw == 0) return 1;
    if (raw > depth) return depth;
    return raw;
  endfunction

  // reload start state and empty both windows
  function automatic void restart_model();
    pos_q = longint'($signed(model_cfg.start_position));
    vel_q = longint'($signed(model_cfg.start_velocity));
    foreach (short_win[k]) short_win[k] = 0;
    foreach (long_win[k]) long_win[k] = 0;
    short_total = 0;
    long_total  = 0;
    short_at    = 0;
    long_at     = 0;
  endfunction

  function automatic void apply_reg(cfg_idx_e idx, logic [31:0] data);
    case (idx)
      CFG_STEP_SIZE:      model_cfg.step_size           = data[16:0];
      CFG_STREAM_SPEED:   model_cfg.stream_speed        = data;
      CFG_START_POSITION: model_cfg.start_position      = data;
      CFG_START_VELOCITY: model_cfg.start_velocity      = data;
      CFG_SHORT_LENGTH:   model_cfg.short_window_length = data[12:0];
      CFG_LONG_LENGTH:    model_cfg.long_window_length  = data[14:0];
      CFG_SHORT_SCALE:    model_cfg.short_window_scale  = data[16:0];
      default:            model_cfg.long_window_scale   = data[16:0];
    endcase
  endfunction

  // one euler-maruyama step; all products floor-shifted by 16
  function automatic out_t step_particle(in_t item);
    longint dt;
    longint vs;
    longint noise;
    longint x;
    longint v;
    longint drift;
    longint work;
    longint vsum;
    longint sgn;
    int     len;
    out_t   res;
    dt    = longint'(model_cfg.step_size);
    vs    = longint'($signed(model_cfg.stream_speed));
    noise = longint'($signed(item.noise_sample));
    if (item.restart) restart_model();
    x = pos_q;
    v = vel_q;
    // work against the stream uses the old position
    drift = clip32((vs * dt) >>> 16);
    work  = clip32((-drift * x) >>> 16);
    // friction sign of the exact sum v + stream speed
    vsum = v + vs;
    sgn  = (vsum > 0) ? longint'(Q_ONE) : ((vsum < 0) ? -longint'(Q_ONE) : 64'sd0);
    pos_q = clip32(x + ((dt * v) >>> 16));
    vel_q = clip32(v + ((dt * (-sgn - x)) >>> 16)
                     + ((longint'(NOISE_GAIN) * noise) >>> 16));
    // short window: a pointer left beyond a shrunk length restarts at slot 0
    len = window_len(int'(model_cfg.short_window_length), SHORT_DEPTH);
    if (short_at >= len) short_at = 0;
    short_total += work - short_win[short_at];
    short_win[short_at] = work;
    short_at = (short_at + 1 >= len) ? 0 : short_at + 1;
    // long window, same rules
    len = window_len(int'(model_cfg.long_window_length), LONG_DEPTH);
    if (long_at >= len) long_at = 0;
    long_total += work - long_win[long_at];
    long_win[long_at] = work;
    long_at = (long_at + 1 >= len) ? 0 : long_at + 1;
    res.position        = pos_q[31:0];
    res.velocity        = vel_q[31:0];
    res.short_work_mean = 32'(clip32((short_total
                                      * longint'(model_cfg.short_window_scale)) >>> 16));
    res.long_work_mean  = 32'(clip32((long_total
                                      * longint'(model_cfg.long_window_scale)) >>> 16));
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // random helpers
  // ---------------------------------------------------------------------

  // idle stretch drawn from three ranges, the shortest most often and the longest rarely
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  // sometimes sets the unused upper bits of a narrow register write
  function automatic logic [31:0] with_junk(logic [31:0] value, int width);
    logic [31:0] keep;
    keep = (width >= 32) ? 32'hFFFF_FFFF : ((32'd1 << width) - 32'd1);
    if ($urandom_range(0, 3) == 0) return (value & keep) | ($urandom & ~keep);
    return value & keep;
  endfunction

  // noise near the physical spread most of the time, full range otherwise
  function automatic logic [31:0] pick_noise();
    if ($urandom_range(0, 99) < 80)
      return int'($urandom_range(0, 8000)) + int'($urandom_range(0, 8000)) - 8000;
    return $urandom;
  endfunction

  function automatic logic [31:0] pick_small_q(int span);
    if ($urandom_range(0, 99) < 80)
      return int'($urandom_range(0, 2 * span)) - span;
    return $urandom;
  endfunction

  // ---------------------------------------------------------------------
  // clock, reset, result side
  // ---------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // result-side back pressure, changed only on the falling edge
  initial begin : result_stalls
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (out_stalls_on && $urandom_range(0, 99) < 30) begin
        out_ready_i <= 1'b0;
        repeat (idle_len()) @(negedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      n_errors++;
      if (n_errors <= SHOWN_MAX)
        $display("mismatch in %s of result %0d: expected %0d (%h), got %0d (%h)",
                 name, n_results, $signed(want), want, $signed(got), got);
    end
  endfunction

  // every result beat is matched against the oldest prediction
  always @(posedge clk_i) begin : result_check
    out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_results++;
      if (pending_results.size() == 0) begin
        n_errors++;
        if (n_errors <= SHOWN_MAX)
          $display("result beat %0d arrived with no step pending: %h",
                   n_results, out_data_o);
      end else begin
        want = pending_results.pop_front();
        check_field("position", want.position, out_data_o.position);
        check_field("velocity", want.velocity, out_data_o.velocity);
        check_field("short_work_mean", want.short_work_mean, out_data_o.short_work_mean);
        check_field("long_work_mean", want.long_work_mean, out_data_o.long_work_mean);
      end
    end
  end

  // watchdog: any beat on any channel counts as progress
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)
          || (cfg_valid_i && cfg_ready_o))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("no beat moved for %0d cycles, %0d results outstanding",
                 QUIET_LIMIT, pending_results.size());
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // channel tasks
  // ---------------------------------------------------------------------

  // valid stays high after acceptance; the next call either reuses it
  // for a back-to-back beat or drops it for a gap
  task automatic send_item(input logic [31:0] noise, input logic restart);
    in_t item;
    int  gap;
    item.noise_sample = noise;
    item.restart      = restart;
    gap = (in_gaps_on && $urandom_range(0, 99) < 35) ? idle_len() : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(step_particle(item));
    n_items++;
    if (restart) n_restarts++;
  endtask

  // stop sending, then hold until every predicted result has come back
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    // leave a margin before touching registers
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [31:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_reg(idx, data);
    n_reg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------

  // state straight out of reset, then noise extremes and a restart
  task automatic test_reset_state();
    in_gaps_on    = 1'b0;
    out_stalls_on = 1'b0;
    send_item(32'h0000_0000, 1'b0);
    send_item(32'h7FFF_FFFF, 1'b0);
    send_item(32'h8000_0000, 1'b0);
    send_item(32'hFFFF_FFFF, 1'b1);
    drain();
  endtask

  // every register at its extremes, including lengths of zero and above
  // depth, step and scales above one, and saturating work and means
  task automatic test_register_extremes();
    write_reg(CFG_STEP_SIZE, 32'hFFFF_FFFF);
    write_reg(CFG_STREAM_SPEED, 32'h8000_0000);
    write_reg(CFG_START_POSITION, 32'h7FFF_FFFF);
    write_reg(CFG_START_VELOCITY, 32'h8000_0000);
    write_reg(CFG_SHORT_LENGTH, 32'd0);
    write_reg(CFG_LONG_LENGTH, 32'd0);
    write_reg(CFG_SHORT_SCALE, 32'h0001_FFFF);
    write_reg(CFG_LONG_SCALE, 32'h0001_FFFF);
    send_item(32'h7FFF_FFFF, 1'b1);
    send_item(32'h0000_0000, 1'b0);
    send_item(32'h8000_0000, 1'b0);
    drain();

    write_reg(CFG_STEP_SIZE, 32'd0);
    write_reg(CFG_STREAM_SPEED, 32'h7FFF_FFFF);
    write_reg(CFG_START_POSITION, 32'h8000_0000);
    write_reg(CFG_START_VELOCITY, 32'h7FFF_FFFF);
    write_reg(CFG_SHORT_LENGTH, 32'd8191);
    write_reg(CFG_LONG_LENGTH, 32'd32767);
    write_reg(CFG_SHORT_SCALE, 32'd0);
    write_reg(CFG_LONG_SCALE, 32'd0);
    send_item(32'h8000_0000, 1'b1);
    send_item(32'h7FFF_FFFF, 1'b0);
    send_item(32'h0000_0001, 1'b0);
    drain();

    // work saturates, so the window sums overflow 32 bits after two steps
    write_reg(CFG_STEP_SIZE, 32'd65536);
    write_reg(CFG_START_POSITION, 32'h7FFF_FFFF);
    write_reg(CFG_SHORT_LENGTH, 32'd4096);
    write_reg(CFG_LONG_LENGTH, 32'd16384);
    write_reg(CFG_SHORT_SCALE, 32'd65536);
    write_reg(CFG_LONG_SCALE, 32'd65536);
    send_item(32'h0000_0000, 1'b1);
    send_item(32'h0000_0000, 1'b0);
    send_item(32'hFFFF_FFFF, 1'b0);
    drain();
  endtask

  // velocity exactly against the stream: friction sign is zero
  task automatic test_zero_friction();
    write_reg(CFG_STEP_SIZE, 32'd0);
    write_reg(CFG_STREAM_SPEED, 32'd196608);
    write_reg(CFG_START_VELOCITY, -32'sd196608);
    write_reg(CFG_START_POSITION, 32'd0);
    send_item(32'h0000_0000, 1'b1);
    send_item(32'h0000_0000, 1'b0);
    drain();
  endtask

  // fresh register settings; lengths mostly small so the windows wrap
  task automatic pick_config();
    int r;
    logic [31:0] val;
    r = $urandom_range(0, 99);
    if (r < 80) val = $urandom_range(16, 2048);
    else if (r < 88) val = 0;
    else if (r < 94) val = 65536;
    else val = $urandom_range(0, 17'h1FFFF);
    write_reg(CFG_STEP_SIZE, with_junk(val, 17));
    write_reg(CFG_STREAM_SPEED, pick_small_q(262144));
    write_reg(CFG_START_POSITION, pick_small_q(524288));
    write_reg(CFG_START_VELOCITY, pick_small_q(524288));
    r = $urandom_range(0, 99);
    if (r < 70) val = $urandom_range(1, 64);
    else if (r < 80) val = 0;
    else if (r < 88) val = $urandom_range(4097, 8191);
    else val = $urandom_range(0, 8191);
    write_reg(CFG_SHORT_LENGTH, with_junk(val, 13));
    r = $urandom_range(0, 99);
    if (r < 70) val = $urandom_range(1, 200);
    else if (r < 80) val = 0;
    else if (r < 88) val = $urandom_range(16385, 32767);
    else val = $urandom_range(0, 32767);
    write_reg(CFG_LONG_LENGTH, with_junk(val, 15));
    r = $urandom_range(0, 99);
    val = (r < 75) ? $urandom_range(0, 65536) : ((r < 85) ? 32'h1FFFF : 32'd0);
    write_reg(CFG_SHORT_SCALE, with_junk(val, 17));
    r = $urandom_range(0, 99);
    val = (r < 75) ? $urandom_range(0, 65536) : ((r < 85) ? 32'h1FFFF : 32'd0);
    write_reg(CFG_LONG_SCALE, with_junk(val, 17));
  endtask

  // random walks: new settings per phase; half the phases keep the old
  // windows so a length change meets a pointer and entries left over
  task automatic test_random_walks();
    int  phase_len;
    int  pause_at;
    int  k;
    bit  restart;
    while (n_items < ITEM_TARGET) begin
      drain();
      pick_config();
      in_gaps_on    = ($urandom_range(0, 2) != 0);
      out_stalls_on = ($urandom_range(0, 2) != 0);
      phase_len = $urandom_range(100, 200);
      pause_at  = $urandom_range(10, phase_len - 10);
      for (k = 0; k < phase_len; k++) begin
        // one hold per phase until the unit has returned everything
        if (k == pause_at) drain();
        restart = (k == 0) ? ($urandom_range(0, 1) == 1) : ($urandom_range(0, 99) < 3);
        send_item(pick_noise(), restart);
      end
      n_phases++;
    end
    drain();
  endtask

  // ---------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------
  initial begin : stimulus
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CFG_STEP_SIZE;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    in_data_i     = '0;
    in_gaps_on    = 1'b0;
    out_stalls_on = 1'b0;
    quiet_cycles  = 0;
    n_items       = 0;
    n_results     = 0;
    n_restarts    = 0;
    n_reg_writes  = 0;
    n_phases      = 0;
    n_errors      = 0;
    model_cfg     = CFG_RESET;
    restart_model();
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_state();
    test_register_extremes();
    test_zero_friction();
    test_random_walks();

    repeat (10) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      n_errors += pending_results.size();
      $display("%0d predicted results never arrived", pending_results.size());
    end
    $display("ran %0d steps (%0d with restart) over %0d random phases, %0d register writes",
             n_items, n_restarts, n_phases, n_reg_writes);
    $display("compared %0d result beats, %0d field mismatches", n_results, n_errors);
    if (n_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+hdl
hdl/lews_pkg.sv
hdl/lews_ctrl.sv
hdl/lews_window.sv
hdl/lews_datapath.sv
hdl/langevin_euler_window_step_unit.sv
tb/tb.sv
